FILE: src/chm_pkg.sv
// Shared types and constants for the compass heading pipeline.
`default_nettype none

package chm_pkg;

   // Datapath widths
   localparam int AXIS_W    = 16;
   localparam int AW        = 27;   // CORDIC x, y and angle width
   localparam int ATAN_W    = 22;
   localparam int TABLE_LEN = 24;
   localparam int FRAC_SH   = 10;   // 1/65536 deg down to 1/64 deg

   // Angle constants in 1/65536 degree
   localparam logic [AW-1:0] ANG_180     = AW'(64'd11796480);
   localparam logic [AW-1:0] ANG_360     = AW'(64'd23592960);
   localparam logic [AW-1:0] ANG_360_M1  = AW'(64'd23592959);

   // Headings on the axes, in 1/64 degree
   localparam logic [AXIS_W-1:0] HEAD_NORTH = 16'd0;
   localparam logic [AXIS_W-1:0] HEAD_EAST  = 16'd5760;
   localparam logic [AXIS_W-1:0] HEAD_SOUTH = 16'd11520;
   localparam logic [AXIS_W-1:0] HEAD_WEST  = 16'd17280;
   localparam logic [AXIS_W-1:0] HEAD_MAX   = 16'd23039;

   // round(atan(2^-i) * 65536) in degrees
   localparam logic [ATAN_W-1:0] ATAN_TAB [TABLE_LEN] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
      22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
      22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
   };

   typedef enum logic [1:0] {
      OP_RAW_X   = 2'd0,
      OP_RAW_Y   = 2'd1,
      OP_RAW_Z   = 2'd2,
      OP_HEADING = 2'd3
   } chm_op_type;

   // One item as it moves down the pipeline
   typedef struct packed {
      logic [AW-1:0]     x;
      logic [AW-1:0]     y;
      logic [AW-1:0]     z;
      logic              calc;    // heading comes from the CORDIC angle
      logic              y_pos;   // sign of the original Y axis
      logic [AXIS_W-1:0] direct;  // raw axis or fixed heading
   } chm_vec_type;

endpackage

`default_nettype wire

FILE: src/chm_prep.sv
// Input stage: axis assembly, opcode decode, axis cases and half-plane turn.
`default_nettype none

module chm_prep (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [7:0]          x_high,
   input  wire logic [7:0]          x_low,
   input  wire logic [7:0]          z_high,
   input  wire logic [7:0]          z_low,
   input  wire logic [7:0]          y_high,
   input  wire logic [7:0]          y_low,
   input  wire logic [1:0]          opcode,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output chm_pkg::chm_vec_type     out_vec
);

   localparam int AW  = chm_pkg::AW;
   localparam int AXW = chm_pkg::AXIS_W;

   logic [AXW-1:0]        xa;
   logic [AXW-1:0]        ya;
   logic [AXW-1:0]        za;
   logic [AW-1:0]         x_ext;
   logic [AW-1:0]         y_ext;
   chm_pkg::chm_vec_type  vec_in;
   chm_pkg::chm_vec_type  vec_ff;
   logic                  valid_ff;

   assign xa = {x_high, x_low};
   assign ya = {y_high, y_low};
   assign za = {z_high, z_low};

   // Axis times 256, sign extended
   assign x_ext = {{(AW-AXW-8){xa[AXW-1]}}, xa, 8'd0};
   assign y_ext = {{(AW-AXW-8){ya[AXW-1]}}, ya, 8'd0};

   // Decode and starting vector
   always_comb begin
      vec_in        = '0;
      vec_in.y_pos  = ~ya[AXW-1];
      if (xa[AXW-1]) begin
         vec_in.x = AW'(-x_ext);
         vec_in.y = AW'(-y_ext);
         vec_in.z = chm_pkg::ANG_180;
      end else begin
         vec_in.x = x_ext;
         vec_in.y = y_ext;
         vec_in.z = '0;
      end
      unique case (chm_pkg::chm_op_type'(opcode))
         chm_pkg::OP_RAW_X: begin
            vec_in.direct = xa;
         end
         chm_pkg::OP_RAW_Y: begin
            vec_in.direct = ya;
         end
         chm_pkg::OP_RAW_Z: begin
            vec_in.direct = za;
         end
         chm_pkg::OP_HEADING: begin
            // vector on an axis gets a fixed heading
            if (ya == '0) begin
               vec_in.direct = xa[AXW-1] ? chm_pkg::HEAD_SOUTH : chm_pkg::HEAD_NORTH;
            end else if (xa == '0) begin
               vec_in.direct = ya[AXW-1] ? chm_pkg::HEAD_WEST : chm_pkg::HEAD_EAST;
            end else begin
               vec_in.calc = 1'b1;
            end
         end
      endcase
   end

   assign in_ready = ~valid_ff | out_ready;

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

`default_nettype wire

FILE: src/chm_cordic_stage.sv
// One vectoring CORDIC iteration with its pipeline register.
`default_nettype none

module chm_cordic_stage #(
   parameter int IDX = 0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire chm_pkg::chm_vec_type in_vec,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output chm_pkg::chm_vec_type     out_vec
);

   localparam int AW = chm_pkg::AW;
   localparam logic [AW-1:0] ATAN_STEP =
      {{(AW-chm_pkg::ATAN_W){1'b0}}, chm_pkg::ATAN_TAB[IDX]};

   logic [AW-1:0]         xs;
   logic [AW-1:0]         ys;
   chm_pkg::chm_vec_type  vec_in;
   chm_pkg::chm_vec_type  vec_ff;
   logic                  valid_ff;

   // Floor shifts of x and y
   assign xs = AW'($signed(in_vec.x) >>> IDX);
   assign ys = AW'($signed(in_vec.y) >>> IDX);

   // Rotate toward the x axis
   always_comb begin
      vec_in = in_vec;
      if ($signed(in_vec.y) > 0) begin
         vec_in.x = in_vec.x + ys;
         vec_in.y = in_vec.y - xs;
         vec_in.z = in_vec.z + ATAN_STEP;
      end else begin
         vec_in.x = in_vec.x - ys;
         vec_in.y = in_vec.y + xs;
         vec_in.z = in_vec.z - ATAN_STEP;
      end
   end

   assign in_ready = ~valid_ff | out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

   // a held stage keeps its item
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |=> (valid_ff && $stable(vec_ff)))
      else $error("cordic stage lost or changed a held request");

endmodule

`default_nettype wire

FILE: src/chm_finish.sv
// Output stage: half-plane clamp, scaling to 1/64 degree and result register.
`default_nettype none

module chm_finish (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire chm_pkg::chm_vec_type in_vec,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [chm_pkg::AXIS_W-1:0] out_value
);

   localparam int AW  = chm_pkg::AW;
   localparam int AXW = chm_pkg::AXIS_W;

   logic [AW-1:0]   z_wrap;
   logic [AW-1:0]   z_clamp;
   logic [AXW-1:0]  value_in;
   logic [AXW-1:0]  value_ff;
   logic            calc_ff;
   logic            valid_ff;

   // Clamp the angle into the half-plane of Y
   always_comb begin
      z_wrap  = in_vec.z;
      z_clamp = in_vec.z;
      if (in_vec.y_pos) begin
         if ($signed(in_vec.z) < 0) begin
            z_clamp = '0;
         end else if ($signed(in_vec.z) > $signed(chm_pkg::ANG_180)) begin
            z_clamp = chm_pkg::ANG_180;
         end
      end else begin
         if ($signed(in_vec.z) < 0) begin
            z_wrap = in_vec.z + chm_pkg::ANG_360;
         end
         if ($signed(z_wrap) < $signed(chm_pkg::ANG_180)) begin
            z_clamp = chm_pkg::ANG_180;
         end else if ($signed(z_wrap) > $signed(chm_pkg::ANG_360_M1)) begin
            z_clamp = chm_pkg::ANG_360_M1;
         end else begin
            z_clamp = z_wrap;
         end
      end
      value_in = in_vec.calc ? z_clamp[chm_pkg::FRAC_SH +: AXW] : in_vec.direct;
   end

   assign in_ready = ~valid_ff | out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         value_ff <= value_in;
         calc_ff  <= in_vec.calc;
      end
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;

   // computed headings stay below 360 degrees
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && calc_ff) |-> (value_ff <= chm_pkg::HEAD_MAX))
      else $error("heading out of range");

endmodule

`default_nettype wire

FILE: src/compass_heading_from_magnetometer_top.sv
// Top level of the magnetometer compass heading pipeline.
// Usage:
//   Request channel (req_valid/req_ready) carries one magnetometer sample as
//   six bytes, X, Z and Y each high byte then low byte, plus an opcode:
//   raw X, raw Y, raw Z, or heading. Response channel (rsp_valid/rsp_ready)
//   returns one signed 16-bit value per request, in request order: the raw
//   axis, or the heading atan2(Y, X) in 1/64 degree, 0 to 23039.
//   From acceptance to rsp_valid a request passes the input stage, one
//   register per CORDIC iteration and the output stage, in that order.
//   Throughput is one request per cycle while the receiver does not stall;
//   the CORDIC iterations are unrolled into a pipeline, one shift-add
//   stage each. Every stage has its own valid bit and takes a new request
//   when it is empty or its successor moves, so a stalled receiver only
//   stops items behind the first full stage and empty slots fill up; once
//   all stages are full, req_ready drops. Nothing is dropped or repeated
//   across a stall.
//   Reset (synchronous, active high) clears all valid bits; the pipeline is
//   empty and ready in the first cycle after reset.
`default_nettype none

module compass_heading_from_magnetometer_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_x_high,
   input  wire logic [7:0]  req_x_low,
   input  wire logic [7:0]  req_z_high,
   input  wire logic [7:0]  req_z_low,
   input  wire logic [7:0]  req_y_high,
   input  wire logic [7:0]  req_y_low,
   input  wire logic [1:0]  req_opcode,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [15:0] rsp_value
);

   localparam int STEPS_USED =
      (CORDIC_STEPS > chm_pkg::TABLE_LEN) ? chm_pkg::TABLE_LEN : CORDIC_STEPS;

   chm_pkg::chm_vec_type  vec   [STEPS_USED+1];
   logic                  valid [STEPS_USED+1];
   logic                  ready [STEPS_USED+1];
   logic [15:0]           value;

   // Input stage
   chm_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .x_high    (req_x_high),
      .x_low     (req_x_low),
      .z_high    (req_z_high),
      .z_low     (req_z_low),
      .y_high    (req_y_high),
      .y_low     (req_y_low),
      .opcode    (req_opcode),
      .out_valid (valid[0]),
      .out_ready (ready[0]),
      .out_vec   (vec[0])
   );

   // CORDIC iterations, one register stage each
   for (genvar i = 0; i < STEPS_USED; i++) begin : g_step
      chm_cordic_stage #(
         .IDX (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[i]),
         .in_ready  (ready[i]),
         .in_vec    (vec[i]),
         .out_valid (valid[i+1]),
         .out_ready (ready[i+1]),
         .out_vec   (vec[i+1])
      );
   end

   // Clamp, scale and hold the response
   chm_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid[STEPS_USED]),
      .in_ready  (ready[STEPS_USED]),
      .in_vec    (vec[STEPS_USED]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_value (value)
   );

   assign rsp_value = $signed(value);

   // an empty output register frees every stage behind it
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request side stalled with empty output");

endmodule

`default_nettype wire
